[sv/ir_remote_frame_encoder_macros.svh]
// ---------------------------------------------------------------------------
// ir remote frame encoder assertion macros
// concurrent assertion shorthands clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef IR_REMOTE_FRAME_ENCODER_MACROS_SVH
`define IR_REMOTE_FRAME_ENCODER_MACROS_SVH

// same-cycle implication
`define IRFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/irfe_pkg.sv]
// ---------------------------------------------------------------------------
// irfe_pkg
// shared types and constants of the ir remote frame encoder
// ---------------------------------------------------------------------------
package irfe_pkg;

    localparam int FRAME_W     = 16;
    localparam int UNITS_W     = 4;
    localparam int PAUSE_W     = 12;
    localparam int GAP_W       = 12;
    localparam int MARK_W      = 6;
    localparam int PUNIT_W     = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int SYM_IDX_W   = 5;
    localparam int QUEUE_DEPTH = 2;

    // index of the stop symbol within a frame
    localparam logic [SYM_IDX_W-1:0] SYM_STOP_IDX = SYM_IDX_W'(FRAME_W + 1);

    localparam logic [1:0] REQ_SINGLE_OUT = 2'd0;
    localparam logic [1:0] REQ_SINGLE_PIN = 2'd1;
    localparam logic [1:0] REQ_COMBO_SPD  = 2'd2;
    localparam logic [1:0] REQ_COMBO_PWM  = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_MARK_PERIODS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_GAP     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_GAP      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SS_GAP       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PAUSE_UNIT   = 3'd4;

    localparam logic [MARK_W-1:0]  RST_MARK_PERIODS = 6'd7;
    localparam logic [GAP_W-1:0]   RST_ZERO_GAP     = 12'd260;
    localparam logic [GAP_W-1:0]   RST_ONE_GAP      = 12'd546;
    localparam logic [GAP_W-1:0]   RST_SS_GAP       = 12'd1014;
    localparam logic [PUNIT_W-1:0] RST_PAUSE_UNIT   = 8'd16;

    localparam logic [2:0] REPEAT_MAX = 3'd4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] channel;
        logic [3:0] mode;
        logic [3:0] output_req;
        logic [3:0] step;
        logic [2:0] function_req;
        logic       pin;
        logic [3:0] blue;
        logic [3:0] red;
    } cmd_t;

    typedef struct packed {
        logic               sym_kind;
        logic               bit_value;
        logic [PAUSE_W-1:0] pause_ms;
        logic [MARK_W-1:0]  mark_len;
        logic [GAP_W-1:0]   gap_us;
        logic               last;
    } sym_t;

    typedef struct packed {
        logic [MARK_W-1:0]  mark_periods;
        logic [GAP_W-1:0]   zero_gap_us;
        logic [GAP_W-1:0]   one_gap_us;
        logic [GAP_W-1:0]   start_stop_gap_us;
        logic [PUNIT_W-1:0] pause_unit_ms;
    } cfg_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [UNITS_W-1:0] units;
    } qent_t;

endpackage

[sv/irfe_front.sv]
// ---------------------------------------------------------------------------
// irfe_front
// builds the frame of one command, tracks toggle and repeat state
// ---------------------------------------------------------------------------
module irfe_front
    import irfe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  cmd_t  cmd,
    output qent_t entry
);

    logic [3:0]         toggle_reg;
    logic [3:0]         toggle_next;
    logic [FRAME_W-1:0] prev_frame_reg;
    logic [FRAME_W-1:0] prev_frame_next;
    logic [2:0]         repeat_reg;
    logic [2:0]         repeat_next;

    logic [3:0]         n1;
    logic [3:0]         n2;
    logic [3:0]         n3;
    logic [3:0]         n4;
    logic [FRAME_W-1:0] frame;
    logic [UNITS_W-1:0] units;
    logic               tog;

    assign tog = toggle_reg[cmd.channel];

    always_comb
    begin
        unique case (cmd.req_type)
            REQ_SINGLE_OUT:
            begin
                n1 = {tog, 1'b0, cmd.channel};
                n2 = 4'h4 | cmd.mode | cmd.output_req;
                n3 = cmd.step;
            end
            REQ_SINGLE_PIN:
            begin
                n1 = {tog, 1'b0, cmd.channel};
                n2 = cmd.mode;
                n3 = {cmd.pin, cmd.function_req};
            end
            REQ_COMBO_SPD:
            begin
                n1 = {2'b00, cmd.channel};
                n2 = 4'h1;
                n3 = cmd.blue | cmd.red;
            end
            default:
            begin
                n1 = {2'b01, cmd.channel};
                n2 = cmd.blue;
                n3 = cmd.red;
            end
        endcase
    end

    assign n4    = ~(n1 ^ n2 ^ n3);
    assign frame = {n1, n2, n3, n4};

    // pause units from channel and the repeat count before this frame
    always_comb
    begin
        unique case (repeat_reg)
            3'd0:       units = UNITS_W'(3'd4 - {1'b0, cmd.channel});
            3'd1, 3'd2: units = UNITS_W'(5);
            3'd3, 3'd4: units = UNITS_W'(6) + UNITS_W'({cmd.channel, 1'b0});
            default:    units = '0;
        endcase
    end

    assign entry.frame = frame;
    assign entry.units = units;

    always_comb
    begin
        toggle_next     = toggle_reg;
        prev_frame_next = prev_frame_reg;
        repeat_next     = repeat_reg;
        if (accept)
        begin
            if (frame == prev_frame_reg)
            begin
                if (repeat_reg < REPEAT_MAX)
                    repeat_next = repeat_reg + 3'd1;
            end
            else
            begin
                prev_frame_next = frame;
                repeat_next     = '0;
            end
            if (cmd.req_type == REQ_SINGLE_OUT || cmd.req_type == REQ_SINGLE_PIN)
                toggle_next[cmd.channel] = ~tog;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg     <= '0;
            prev_frame_reg <= '0;
            repeat_reg     <= '0;
        end
        else
        begin
            toggle_reg     <= toggle_next;
            prev_frame_reg <= prev_frame_next;
            repeat_reg     <= repeat_next;
        end
    end

endmodule

[sv/irfe_queue.sv]
// ---------------------------------------------------------------------------
// irfe_queue
// short queue of built frames between front and back
// ---------------------------------------------------------------------------
module irfe_queue
    import irfe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  qent_t wdata,
    output logic  full,
    input  logic  rd,
    output qent_t rdata,
    output logic  valid
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] PTR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(DEPTH);

    qent_t             mem_reg [DEPTH];
    logic [ADDR_W-1:0] wptr_reg;
    logic [ADDR_W-1:0] rptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign full  = (cnt_reg == CNT_FULL);
    assign valid = (cnt_reg != '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && valid;
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

[sv/irfe_back.sv]
// ---------------------------------------------------------------------------
// irfe_back
// sequences start, sixteen data and stop symbols into the output register
// ---------------------------------------------------------------------------
module irfe_back
    import irfe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  qent_t head,
    input  logic  head_valid,
    output logic  head_pop,
    output sym_t  sym,
    output logic  empty,
    input  logic  pop
);

    logic                 busy_reg;
    logic [SYM_IDX_W-1:0] idx_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic                 out_valid_reg;
    sym_t                 sym_reg;
    sym_t                 sym_next;
    logic                 slot_free;
    logic                 emit;
    logic                 at_stop;

    assign slot_free = !out_valid_reg || pop;
    assign emit      = slot_free && (busy_reg || head_valid);
    assign head_pop  = emit && !busy_reg;
    assign at_stop   = (idx_reg == SYM_STOP_IDX);

    always_comb
    begin
        sym_next          = '0;
        sym_next.mark_len = cfg.mark_periods;
        priority if (!busy_reg)
        begin
            sym_next.pause_ms = PAUSE_W'(head.units) * PAUSE_W'(cfg.pause_unit_ms);
            sym_next.gap_us   = cfg.start_stop_gap_us;
        end
        else if (at_stop)
        begin
            sym_next.gap_us = cfg.start_stop_gap_us;
            sym_next.last   = 1'b1;
        end
        else
        begin
            sym_next.sym_kind  = 1'b1;
            sym_next.bit_value = frame_reg[FRAME_W-1];
            sym_next.gap_us    = frame_reg[FRAME_W-1] ? cfg.one_gap_us : cfg.zero_gap_us;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            sym_reg <= sym_next;
        if (head_pop)
            frame_reg <= head.frame;
        else if (emit && !at_stop)
            frame_reg <= {frame_reg[FRAME_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
            if (head_pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= SYM_IDX_W'(1);
            end
            else if (emit)
            begin
                if (at_stop)
                    busy_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign sym   = sym_reg;
    assign empty = !out_valid_reg;

endmodule

[sv/ir_remote_frame_encoder.sv]
// ---------------------------------------------------------------------------
// ir_remote_frame_encoder
// turns remote commands into 18-symbol pulse-distance frames
// ---------------------------------------------------------------------------
//  channel   direction  handshake             word
//  cmd       in         push / full           cmd_t, one command
//  sym       out        empty / pop           sym_t, one symbol
//  cfg       in         cfg_valid / cfg_ready cfg_addr + cfg_data, one register
//
//  each command yields 18 symbols, one per cycle while pop is held
//  a command occupies the symbol sequencer in the back part until its stop symbol
//  a command is taken while the frame queue has room
//  reset clears toggle bits, repeat tracking, queue and output register
//  a stalled output holds its symbol; commands keep queuing until full
// ---------------------------------------------------------------------------
module ir_remote_frame_encoder
    import irfe_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  cmd_t                  cmd,
    output logic                  empty,
    input  logic                  pop,
    output sym_t                  sym,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    qent_t front_entry;
    qent_t q_head;
    logic  q_valid;
    logic  q_pop;
    logic  accept;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mark_periods      <= RST_MARK_PERIODS;
            cfg_reg.zero_gap_us       <= RST_ZERO_GAP;
            cfg_reg.one_gap_us        <= RST_ONE_GAP;
            cfg_reg.start_stop_gap_us <= RST_SS_GAP;
            cfg_reg.pause_unit_ms     <= RST_PAUSE_UNIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                REG_MARK_PERIODS: cfg_reg.mark_periods      <= cfg_data[MARK_W-1:0];
                REG_ZERO_GAP:     cfg_reg.zero_gap_us       <= cfg_data[GAP_W-1:0];
                REG_ONE_GAP:      cfg_reg.one_gap_us        <= cfg_data[GAP_W-1:0];
                REG_SS_GAP:       cfg_reg.start_stop_gap_us <= cfg_data[GAP_W-1:0];
                REG_PAUSE_UNIT:   cfg_reg.pause_unit_ms     <= cfg_data[PUNIT_W-1:0];
                default:          cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    irfe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd),
        .entry  (front_entry)
    );

    irfe_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (front_entry),
        .full  (full),
        .rd    (q_pop),
        .rdata (q_head),
        .valid (q_valid)
    );

    irfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (q_head),
        .head_valid (q_valid),
        .head_pop   (q_pop),
        .sym        (sym),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

[sv/irfe_checker.sv]
// ---------------------------------------------------------------------------
// irfe_checker
// port-level checks of the ir remote frame encoder, bound to the top level
// ---------------------------------------------------------------------------
`include "ir_remote_frame_encoder_macros.svh"

module irfe_checker
    import irfe_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic empty,
    input logic pop,
    input sym_t sym
);

    logic stop_ok;
    logic data_ok;

    assign stop_ok = !sym.sym_kind && !sym.bit_value && (sym.pause_ms == '0);
    assign data_ok = (sym.pause_ms == '0) && !sym.last;

    // stalled word holds
    `IRFE_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(sym), "stalled word changed")
    // nothing to show right after reset
    `IRFE_ASSERT_NOW(a_reset_empty, !$past(rst_n), empty, "word shown right after reset")
    // stop word shape
    `IRFE_ASSERT_NOW(a_stop_shape, !empty && sym.last, stop_ok, "bad stop word")
    // data words carry no pause and never end a frame
    `IRFE_ASSERT_NOW(a_data_shape, !empty && sym.sym_kind, data_ok, "bad data word")

endmodule

bind ir_remote_frame_encoder irfe_checker u_irfe_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .sym   (sym)
);
